>>> rtl/track_box_intersection_unit_assert.svh
// Assertion macros shared by the checker of the track to box intersection unit.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef TRACK_BOX_INTERSECTION_UNIT_ASSERT_SVH
`define TRACK_BOX_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("track_box_intersection_unit: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("track_box_intersection_unit: assertion failed");

`endif

>>> rtl/tbi_pkg.sv
// Shared types and constants of the track to box intersection unit.
// Depends on nothing; used by tbi_select, tbi_scale and the top level.
package tbi_pkg;

  // Number of spatial axes handled in parallel.
  localparam int AXES = 3;

  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register map.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_CENTRE_Z     = 3'd2,
    REG_HALF_WIDTH_X = 3'd3,
    REG_HALF_WIDTH_Y = 3'd4,
    REG_HALF_WIDTH_Z = 3'd5
  } cfg_reg_t;

endpackage

>>> rtl/tbi_if.sv
// Valid/ready channel interfaces for track beats and result beats.
// Depends on nothing; widths follow the COORD_BITS parameter.
interface tbi_track_if #(parameter int COORD_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] front_x;
  logic [COORD_BITS-1:0] front_y;
  logic [COORD_BITS-1:0] front_z;
  logic [COORD_BITS-1:0] back_x;
  logic [COORD_BITS-1:0] back_y;
  logic [COORD_BITS-1:0] back_z;

  modport source (output valid, front_x, front_y, front_z, back_x, back_y, back_z,
                  input ready);
  modport sink (input valid, front_x, front_y, front_z, back_x, back_y, back_z,
                output ready);
endinterface

interface tbi_result_if #(parameter int COORD_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [COORD_BITS-1:0] vertex_x;
  logic [COORD_BITS-1:0] vertex_y;
  logic [COORD_BITS-1:0] vertex_z;

  modport source (output valid, hit, vertex_x, vertex_y, vertex_z, input ready);
  modport sink (input valid, hit, vertex_x, vertex_y, vertex_z, output ready);
endinterface

>>> rtl/tbi_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with fraction bits.
// Depends on nothing; instantiated per slab bound by the top level.
module tbi_divider #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 33,
  parameter int FRAC_W = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  input  logic                      neg_in,
  output logic                      out_valid,
  output logic [NUM_W+FRAC_W-1:0]   quo,
  output logic                      neg_out
);

  localparam int QW = NUM_W + FRAC_W;

  logic [DEN_W-1:0] rem   [QW];
  logic [QW-1:0]    dq    [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic             neg_r [QW];
  logic             vld   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [QW-1:0]    dq_i;
    logic [DEN_W-1:0] den_i;
    logic             neg_i;
    logic             vld_i;
    logic [DEN_W:0]   cand;
    logic             take;

    // Stage inputs come from the ports or from the previous stage.
    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign dq_i  = {num, {FRAC_W{1'b0}}};
      assign den_i = den;
      assign neg_i = neg_in;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem[s-1];
      assign dq_i  = dq[s-1];
      assign den_i = den_r[s-1];
      assign neg_i = neg_r[s-1];
      assign vld_i = vld[s-1];
    end

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign cand = {rem_i, dq_i[QW-1]};
    assign take = (cand >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s]   <= take ? DEN_W'(cand - {1'b0, den_i}) : cand[DEN_W-1:0];
        dq[s]    <= {dq_i[QW-2:0], take};
        den_r[s] <= den_i;
        neg_r[s] <= neg_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = dq[QW-1];
  assign neg_out   = neg_r[QW-1];

endmodule

>>> rtl/tbi_delay.sv
// Fixed-depth register line that keeps side data aligned with the pipeline.
// Depends on nothing; advances on the shared pipeline enable.
module tbi_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift the whole line by one place per advancing cycle.
  always_ff @(posedge clk) begin
    if (adv) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

>>> rtl/tbi_select.sv
// Slab ratio ordering, entry/exit reduction over axes and miss decision.
// Depends on tbi_pkg; three register stages fed by the dividers.
module tbi_select #(
  parameter int COORD_BITS      = 32,
  parameter int RATIO_FRAC_BITS = 24
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           adv,
  input  logic                                           in_valid,
  input  logic [tbi_pkg::AXES-1:0][COORD_BITS+RATIO_FRAC_BITS+1:0] q_lo,
  input  logic [tbi_pkg::AXES-1:0][COORD_BITS+RATIO_FRAC_BITS+1:0] q_hi,
  input  logic [tbi_pkg::AXES-1:0]                       neg_lo,
  input  logic [tbi_pkg::AXES-1:0]                       neg_hi,
  input  logic [tbi_pkg::AXES-1:0]                       active,
  input  logic                                           zmiss,
  output logic                                           out_valid,
  output logic                                           miss,
  output logic                                           tneg,
  output logic [COORD_BITS+RATIO_FRAC_BITS:0]            tmag
);

  localparam int N  = COORD_BITS;
  localparam int F  = RATIO_FRAC_BITS;
  localparam int QW = N + F + 2;
  localparam int TW = N + F + 1;
  localparam logic [QW-1:0] TLIM = QW'(1) << (N + F);

  // Stage A: signed ratios, ordered per axis.
  logic [QW:0] lo_v [tbi_pkg::AXES];
  logic [QW:0] hi_v [tbi_pkg::AXES];
  logic [QW:0] tmin [tbi_pkg::AXES];
  logic [QW:0] tmax [tbi_pkg::AXES];
  logic [tbi_pkg::AXES-1:0] act_a;
  logic zm_a, v_a;

  always_comb begin
    for (int a = 0; a < tbi_pkg::AXES; a++) begin
      lo_v[a] = neg_lo[a] ? -{1'b0, q_lo[a]} : {1'b0, q_lo[a]};
      hi_v[a] = neg_hi[a] ? -{1'b0, q_hi[a]} : {1'b0, q_hi[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        if ($signed(hi_v[a]) < $signed(lo_v[a])) begin
          tmin[a] <= hi_v[a];
          tmax[a] <= lo_v[a];
        end else begin
          tmin[a] <= lo_v[a];
          tmax[a] <= hi_v[a];
        end
      end
      act_a <= active;
      zm_a  <= zmiss;
    end
  end

  // Stage B: latest entry and earliest exit over the axes that move.
  logic [QW:0] tn_next, tf_next, tn_b, tf_b;
  logic any_next, any_b, zm_b, v_b;

  always_comb begin
    tn_next  = '0;
    tf_next  = '0;
    any_next = 1'b0;
    for (int a = 0; a < tbi_pkg::AXES; a++) begin
      if (act_a[a]) begin
        if (!any_next || ($signed(tmin[a]) > $signed(tn_next))) begin
          tn_next = tmin[a];
        end
        if (!any_next || ($signed(tmax[a]) < $signed(tf_next))) begin
          tf_next = tmax[a];
        end
        any_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tn_b  <= tn_next;
      tf_b  <= tf_next;
      any_b <= any_next;
      zm_b  <= zm_a;
    end
  end

  // Stage C: miss decision and clamped entry magnitude.
  logic [QW:0]   tn_abs;
  logic [QW-1:0] tn_mag;

  assign tn_abs = tn_b[QW] ? -tn_b : tn_b;
  assign tn_mag = tn_abs[QW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      miss <= zm_b || (any_b && ($signed(tf_b) < $signed(tn_b)));
      tneg <= tn_b[QW];
      tmag <= (tn_mag > TLIM) ? TW'(TLIM) : TW'(tn_mag);
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_a       <= in_valid;
      v_b       <= v_a;
      out_valid <= v_b;
    end
  end

endmodule

>>> rtl/tbi_scale.sv
// Vertex construction: direction times entry ratio, added to the front point.
// Depends on tbi_pkg; holds the output register of the block.
module tbi_scale #(
  parameter int COORD_BITS      = 32,
  parameter int RATIO_FRAC_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     adv,
  input  logic                                     in_valid,
  input  logic                                     miss,
  input  logic                                     tneg,
  input  logic [COORD_BITS+RATIO_FRAC_BITS:0]      tmag,
  input  logic [tbi_pkg::AXES-1:0][COORD_BITS-1:0] f,
  input  logic [tbi_pkg::AXES-1:0]                 dneg,
  input  logic [tbi_pkg::AXES-1:0][COORD_BITS:0]   dmag,
  output logic                                     out_valid,
  output logic                                     hit,
  output logic [tbi_pkg::AXES-1:0][COORD_BITS-1:0] vertex
);

  localparam int N   = COORD_BITS;
  localparam int F   = RATIO_FRAC_BITS;
  localparam int TW  = N + F + 1;
  localparam int K   = (TW + 1) / 2;
  localparam int HW  = TW - K;
  localparam int PLW = N + 1 + K;
  localparam int PHW = N + 1 + HW;
  localparam int SW  = N + 1 + TW;
  localparam int MW  = SW - F;
  localparam logic [MW-1:0]  MLIM = MW'(1) << N;
  localparam logic [N+1:0]   SMAX = {3'b000, {(N-1){1'b1}}};
  localparam logic [N+1:0]   SMIN = {3'b111, {(N-1){1'b0}}};

  // Stage 1: low partial product.
  logic [PLW-1:0] plo1 [tbi_pkg::AXES];
  logic [N:0]     dmag1 [tbi_pkg::AXES];
  logic [N-1:0]   f1 [tbi_pkg::AXES];
  logic [tbi_pkg::AXES-1:0] sg1;
  logic [HW-1:0]  thi1;
  logic miss1, v1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        plo1[a]  <= {{K{1'b0}}, dmag[a]} * {{(N+1){1'b0}}, tmag[K-1:0]};
        dmag1[a] <= dmag[a];
        f1[a]    <= f[a];
        sg1[a]   <= tneg ^ dneg[a];
      end
      thi1  <= tmag[TW-1:K];
      miss1 <= miss;
    end
  end

  // Stage 2: high partial product.
  logic [PHW-1:0] phi2 [tbi_pkg::AXES];
  logic [PLW-1:0] plo2 [tbi_pkg::AXES];
  logic [N-1:0]   f2 [tbi_pkg::AXES];
  logic [tbi_pkg::AXES-1:0] sg2;
  logic miss2, v2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        phi2[a] <= {{HW{1'b0}}, dmag1[a]} * {{(N+1){1'b0}}, thi1};
        plo2[a] <= plo1[a];
        f2[a]   <= f1[a];
      end
      sg2   <= sg1;
      miss2 <= miss1;
    end
  end

  // Stage 3: join the partial products, drop fraction bits and clamp.
  logic [SW-1:0] sum3 [tbi_pkg::AXES];
  logic [MW-1:0] mr3  [tbi_pkg::AXES];
  logic [N:0]    m3   [tbi_pkg::AXES];
  logic [N-1:0]  f3   [tbi_pkg::AXES];
  logic [tbi_pkg::AXES-1:0] sg3;
  logic miss3, v3;

  always_comb begin
    for (int a = 0; a < tbi_pkg::AXES; a++) begin
      sum3[a] = {phi2[a], {K{1'b0}}} + {{HW{1'b0}}, plo2[a]};
      mr3[a]  = sum3[a][SW-1:F];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        m3[a] <= (mr3[a] > MLIM) ? MLIM[N:0] : mr3[a][N:0];
        f3[a] <= f2[a];
      end
      sg3   <= sg2;
      miss3 <= miss2;
    end
  end

  // Stage 4: signed offset, saturation and the output register.
  logic [N+1:0] vs [tbi_pkg::AXES];

  always_comb begin
    for (int a = 0; a < tbi_pkg::AXES; a++) begin
      vs[a] = sg3[a] ? ({{2{f3[a][N-1]}}, f3[a]} - {1'b0, m3[a]})
                     : ({{2{f3[a][N-1]}}, f3[a]} + {1'b0, m3[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= !miss3;
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        if (miss3) begin
          vertex[a] <= '0;
        end else if ($signed(vs[a]) > $signed(SMAX)) begin
          vertex[a] <= SMAX[N-1:0];
        end else if ($signed(vs[a]) < $signed(SMIN)) begin
          vertex[a] <= SMIN[N-1:0];
        end else begin
          vertex[a] <= vs[a][N-1:0];
        end
      end
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

>>> rtl/track_box_intersection_unit.sv
// Track to box intersection unit: top level with box registers and pipeline glue.
// Depends on tbi_pkg, tbi_if, tbi_divider, tbi_delay, tbi_select and tbi_scale.
//
// Usage: each beat on the track channel carries a front and a back hit point.
// The block intersects the line through them with the box held in the six
// configuration registers (centre and half widths, written over the plain
// write port; the user writes them only while the block is idle, which the block
// does not enforce) and returns one beat on the result channel: a hit flag and the
// first crossing point, or all zeros on a miss. A beat passes from the accepting
// edge to a valid result through COORD_BITS + RATIO_FRAC_BITS + 10 register stages:
// one input stage, one divider stage per quotient bit, three selection stages, three
// multiply stages and the output register. The six dividers are fully pipelined, so
// one beat is accepted every cycle while the pipeline does not hold, and results
// leave in input order. All stages share one enable: when the result register holds
// a beat the receiver has not taken, the whole pipeline holds and the track channel
// deasserts ready; nothing is dropped or repeated. Reset clears every valid bit and
// the box registers; no clearing pass is needed.
module track_box_intersection_unit #(
  parameter int COORD_BITS      = 32,
  parameter int RATIO_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [tbi_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [COORD_BITS-1:0]              wr_data,
  tbi_track_if.sink                          track,
  tbi_result_if.source                       result
);

  localparam int N  = COORD_BITS;
  localparam int F  = RATIO_FRAC_BITS;
  localparam int NW = N + 2;
  localparam int DW = N + 1;
  localparam int QW = N + F + 2;
  localparam int TW = N + F + 1;

  // Box registers.
  logic [N-1:0] centre [tbi_pkg::AXES];
  logic [N-2:0] half   [tbi_pkg::AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        centre[a] <= '0;
        half[a]   <= '0;
      end
    end else if (wr_en) begin
      case (tbi_pkg::cfg_reg_t'(wr_index))
        tbi_pkg::REG_CENTRE_X:     centre[0] <= wr_data;
        tbi_pkg::REG_CENTRE_Y:     centre[1] <= wr_data;
        tbi_pkg::REG_CENTRE_Z:     centre[2] <= wr_data;
        tbi_pkg::REG_HALF_WIDTH_X: half[0]   <= wr_data[N-2:0];
        tbi_pkg::REG_HALF_WIDTH_Y: half[1]   <= wr_data[N-2:0];
        tbi_pkg::REG_HALF_WIDTH_Z: half[2]   <= wr_data[N-2:0];
        default: ;
      endcase
    end
  end

  // Shared pipeline enable: advance unless a result waits at the output.
  logic adv;
  logic out_valid;

  assign adv         = !out_valid || result.ready;
  assign track.ready = adv;

  // Input stage: direction, slab numerators and zero-direction test.
  logic [N-1:0] f_in [tbi_pkg::AXES];
  logic [N-1:0] b_in [tbi_pkg::AXES];
  logic [N+1:0] f_s [tbi_pkg::AXES];
  logic [N+1:0] d_s [tbi_pkg::AXES];
  logic [N+1:0] lo_s [tbi_pkg::AXES];
  logic [N+1:0] hi_s [tbi_pkg::AXES];
  logic [N+1:0] nlo_s [tbi_pkg::AXES];
  logic [N+1:0] nhi_s [tbi_pkg::AXES];
  logic [tbi_pkg::AXES-1:0] zmiss_ax;

  assign f_in[0] = track.front_x;
  assign f_in[1] = track.front_y;
  assign f_in[2] = track.front_z;
  assign b_in[0] = track.back_x;
  assign b_in[1] = track.back_y;
  assign b_in[2] = track.back_z;

  always_comb begin
    for (int a = 0; a < tbi_pkg::AXES; a++) begin
      f_s[a]   = {{2{f_in[a][N-1]}}, f_in[a]};
      d_s[a]   = {{2{b_in[a][N-1]}}, b_in[a]} - f_s[a];
      lo_s[a]  = {{2{centre[a][N-1]}}, centre[a]} - {3'b000, half[a]};
      hi_s[a]  = {{2{centre[a][N-1]}}, centre[a]} + {3'b000, half[a]};
      nlo_s[a] = lo_s[a] - f_s[a];
      nhi_s[a] = hi_s[a] - f_s[a];
      zmiss_ax[a] = (d_s[a] == '0) &&
                    (($signed(f_s[a]) < $signed(lo_s[a])) ||
                     ($signed(f_s[a]) > $signed(hi_s[a])));
    end
  end

  logic v0;
  logic [tbi_pkg::AXES-1:0][N-1:0]  f0;
  logic [tbi_pkg::AXES-1:0][DW-1:0] dmag0;
  logic [tbi_pkg::AXES-1:0]         dneg0;
  logic [tbi_pkg::AXES-1:0]         act0;
  logic [tbi_pkg::AXES-1:0][NW-1:0] nlo_mag0;
  logic [tbi_pkg::AXES-1:0][NW-1:0] nhi_mag0;
  logic [tbi_pkg::AXES-1:0]         nlo_neg0;
  logic [tbi_pkg::AXES-1:0]         nhi_neg0;
  logic                             zmiss0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= track.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < tbi_pkg::AXES; a++) begin
        f0[a]       <= f_in[a];
        dneg0[a]    <= d_s[a][N+1];
        dmag0[a]    <= d_s[a][N+1] ? DW'(-d_s[a]) : DW'(d_s[a]);
        act0[a]     <= (d_s[a] != '0);
        nlo_neg0[a] <= nlo_s[a][N+1];
        nhi_neg0[a] <= nhi_s[a][N+1];
        nlo_mag0[a] <= nlo_s[a][N+1] ? -nlo_s[a] : nlo_s[a];
        nhi_mag0[a] <= nhi_s[a][N+1] ? -nhi_s[a] : nhi_s[a];
      end
      zmiss0 <= |zmiss_ax;
    end
  end

  // Slab ratio dividers, two per axis.
  logic [tbi_pkg::AXES-1:0][QW-1:0] q_lo, q_hi;
  logic [tbi_pkg::AXES-1:0]         qn_lo, qn_hi;
  logic [tbi_pkg::AXES-1:0]         dv_lo, dv_hi;

  for (genvar a = 0; a < tbi_pkg::AXES; a++) begin : g_axis
    tbi_divider #(.NUM_W(NW), .DEN_W(DW), .FRAC_W(F)) u_div_lo (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (v0),
      .num       (nlo_mag0[a]),
      .den       (dmag0[a]),
      .neg_in    (nlo_neg0[a] ^ dneg0[a]),
      .out_valid (dv_lo[a]),
      .quo       (q_lo[a]),
      .neg_out   (qn_lo[a])
    );

    tbi_divider #(.NUM_W(NW), .DEN_W(DW), .FRAC_W(F)) u_div_hi (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (v0),
      .num       (nhi_mag0[a]),
      .den       (dmag0[a]),
      .neg_in    (nhi_neg0[a] ^ dneg0[a]),
      .out_valid (dv_hi[a]),
      .quo       (q_hi[a]),
      .neg_out   (qn_hi[a])
    );
  end

  // Axis flags follow the dividers; coordinates wait for the ordering stages too.
  logic [tbi_pkg::AXES-1:0] act_d;
  logic                     zmiss_d;
  logic [tbi_pkg::AXES-1:0][N-1:0]  f_d;
  logic [tbi_pkg::AXES-1:0]         dneg_d;
  logic [tbi_pkg::AXES-1:0][DW-1:0] dmag_d;

  tbi_delay #(.WIDTH(tbi_pkg::AXES + 1), .DEPTH(QW)) u_flag_delay (
    .clk  (clk),
    .adv  (adv),
    .din  ({act0, zmiss0}),
    .dout ({act_d, zmiss_d})
  );

  tbi_delay #(.WIDTH(tbi_pkg::AXES * (2 * N + 2)), .DEPTH(QW + 3)) u_point_delay (
    .clk  (clk),
    .adv  (adv),
    .din  ({f0, dneg0, dmag0}),
    .dout ({f_d, dneg_d, dmag_d})
  );

  // Entry and exit ratio selection.
  logic          sel_valid, sel_miss, sel_tneg;
  logic [TW-1:0] sel_tmag;

  tbi_select #(.COORD_BITS(N), .RATIO_FRAC_BITS(F)) u_select (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  ((&dv_lo) & (&dv_hi)),
    .q_lo      (q_lo),
    .q_hi      (q_hi),
    .neg_lo    (qn_lo),
    .neg_hi    (qn_hi),
    .active    (act_d),
    .zmiss     (zmiss_d),
    .out_valid (sel_valid),
    .miss      (sel_miss),
    .tneg      (sel_tneg),
    .tmag      (sel_tmag)
  );

  // Vertex computation and output register.
  logic [tbi_pkg::AXES-1:0][N-1:0] vertex;

  tbi_scale #(.COORD_BITS(N), .RATIO_FRAC_BITS(F)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sel_valid),
    .miss      (sel_miss),
    .tneg      (sel_tneg),
    .tmag      (sel_tmag),
    .f         (f_d),
    .dneg      (dneg_d),
    .dmag      (dmag_d),
    .out_valid (out_valid),
    .hit       (result.hit),
    .vertex    (vertex)
  );

  assign result.valid    = out_valid;
  assign result.vertex_x = vertex[0];
  assign result.vertex_y = vertex[1];
  assign result.vertex_z = vertex[2];

endmodule

>>> rtl/tbi_checker.sv
// Port-level checker of the track to box intersection unit, bound to the top.
// Depends on track_box_intersection_unit_assert.svh.
`include "track_box_intersection_unit_assert.svh"

module tbi_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  hit,
  input logic [COORD_BITS-1:0] vertex_x,
  input logic [COORD_BITS-1:0] vertex_y,
  input logic [COORD_BITS-1:0] vertex_z
);

  // A missed track always reports the origin.
  `TBI_ASSERT_NOW(a_miss_zero, out_valid && !hit, vertex_x == '0 && vertex_y == '0 && vertex_z == '0)

  // A stalled result beat is held unchanged.
  `TBI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(vertex_x) && $stable(vertex_y) && $stable(vertex_z))

  // An empty output register never blocks the track channel.
  `TBI_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

  // A stalled result freezes the pipeline and so blocks the track channel.
  `TBI_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)

  // Reset leaves no result beat behind.
  `TBI_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind track_box_intersection_unit tbi_checker #(.COORD_BITS(COORD_BITS)) u_tbi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (track.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .hit       (result.hit),
  .vertex_x  (result.vertex_x),
  .vertex_y  (result.vertex_y),
  .vertex_z  (result.vertex_z)
);
